// ===== rtl/core/vertex_rotate_project_defines.svh =====
// assertion macros for the vertex rotate and project block
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

// same cycle implication
`define VRP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vrp check failed");

// next cycle implication
`define VRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vrp check failed");

`endif

// ===== rtl/core/vrp_pkg.sv =====
// shared types, constants and helper functions for the vertex rotate and project block
package vrp_pkg;

    localparam int COORD_W   = 12;
    localparam int ANG_W     = 9;
    localparam int TRIG_FRAC = 14;
    localparam int TRIG_W    = TRIG_FRAC + 2;
    localparam int ROT_W     = 13;
    localparam int WIDE_W    = ROT_W + 1;
    localparam int PROD_W    = WIDE_W + TRIG_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int SCR_W     = 16;
    localparam int FOCAL_W   = 10;
    localparam int OFFSET_W  = 12;
    localparam int DEN_W     = 15;
    localparam int DIVD_W    = DEN_W - 1;
    localparam int PROJ_W    = ROT_W + FOCAL_W + 1;
    localparam int NUM_W     = PROJ_W - 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [FOCAL_W-1:0]  FOCAL_RESET  = 10'd150;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;

    localparam logic [ANG_W-1:0] DEG_90  = 9'd90;
    localparam logic [ANG_W-1:0] DEG_180 = 9'd180;
    localparam logic [ANG_W-1:0] DEG_270 = 9'd270;
    localparam logic [ANG_W:0]   DEG_360 = 10'd360;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_SAT = 2'd1,
        STATUS_DEN = 2'd2
    } status_t;

    typedef struct packed {
        logic valid;
        logic last;
    } vrp_ctl_t;

    // sin of 0..90 degrees, q1.14 rounded to nearest
    localparam logic [TRIG_FRAC:0] SIN_QUARTER [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [ANG_W-1:0] d);
        logic [ANG_W-1:0]  idx;
        logic              neg;
        logic [TRIG_W-1:0] mag;
        if (d <= DEG_90) begin
            idx = d;
            neg = 1'b0;
        end else if (d <= DEG_180) begin
            idx = DEG_180 - d;
            neg = 1'b0;
        end else if (d <= DEG_270) begin
            idx = d - DEG_180;
            neg = 1'b1;
        end else begin
            idx = ANG_W'(DEG_360 - {1'b0, d});
            neg = 1'b1;
        end
        mag = {1'b0, SIN_QUARTER[idx[6:0]]};
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [TRIG_W-1:0] cos_deg(input logic [ANG_W-1:0] d);
        logic [ANG_W:0] s;
        s = {1'b0, d} + {1'b0, DEG_90};
        if (s >= DEG_360)
            s = s - DEG_360;
        return sin_deg(s[ANG_W-1:0]);
    endfunction

    function automatic logic [ANG_W-1:0] wrap_deg(input logic [ANG_W-1:0] d);
        logic [ANG_W:0] w;
        w = {1'b0, d};
        if (w >= DEG_360)
            w = w - DEG_360;
        return w[ANG_W-1:0];
    endfunction

    // drop fraction bits, rounding toward zero
    function automatic logic signed [WIDE_W-1:0] trunc_q(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] adj;
        adj = v + (v[SUM_W-1] ? SUM_W'((1 << TRIG_FRAC) - 1) : SUM_W'(0));
        return adj[TRIG_FRAC+WIDE_W-1:TRIG_FRAC];
    endfunction

    function automatic logic signed [ROT_W-1:0] sat_rot(input logic signed [WIDE_W-1:0] v);
        if (v[WIDE_W-1] != v[WIDE_W-2])
            return v[WIDE_W-1] ? {1'b1, {(ROT_W-1){1'b0}}} : {1'b0, {(ROT_W-1){1'b1}}};
        return v[ROT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/vertex_rotate_project.sv =====
// top level: euler rotation and perspective projection pipeline
// stages in order: lookup, rotations about z, y and x, depth, scale multiply,
// divider, saturate
// throughput: one word per cycle; the whole pipeline holds while an output word waits
// reset: pipeline emptied, focal length 150, depth offset 256
module vertex_rotate_project (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [vrp_pkg::COORD_W-1:0]     point_x,
    input  logic signed [vrp_pkg::COORD_W-1:0]     point_y,
    input  logic signed [vrp_pkg::COORD_W-1:0]     point_z,
    input  logic        [vrp_pkg::ANG_W-1:0]       angle_x,
    input  logic        [vrp_pkg::ANG_W-1:0]       angle_y,
    input  logic        [vrp_pkg::ANG_W-1:0]       angle_z,
    input  logic                                   last_vertex,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [vrp_pkg::ROT_W-1:0]       rot_x,
    output logic signed [vrp_pkg::ROT_W-1:0]       rot_y,
    output logic signed [vrp_pkg::ROT_W-1:0]       rot_z,
    output logic signed [vrp_pkg::SCR_W-1:0]       screen_x,
    output logic signed [vrp_pkg::SCR_W-1:0]       screen_y,
    output logic        [1:0]                      status,
    output logic                                   last_vertex_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [vrp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [vrp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import vrp_pkg::*;

    localparam int SIDE_Z = WIDE_W + 4 * TRIG_W;
    localparam int SIDE_Y = WIDE_W + 2 * TRIG_W;
    localparam int SIDE_X = WIDE_W;
    localparam int SIDE_D = 3 * ROT_W + 3;
    localparam logic [NUM_W-1:0] POS_LIMIT = NUM_W'((1 << (SCR_W - 1)) - 1);
    localparam logic [NUM_W-1:0] NEG_LIMIT = NUM_W'(1 << (SCR_W - 1));

    logic                  en;
    logic [FOCAL_W-1:0]    focal_reg;
    logic [OFFSET_W-1:0]   offset_reg;

    vrp_ctl_t              ctl_in, ctl_t, ctl_z, ctl_y, ctl_x, ctl_d;
    logic signed [WIDE_W-1:0] px_t, py_t, pz_t;
    logic signed [TRIG_W-1:0] cx_t, sx_t, cy_t, sy_t, cz_t, sz_t;

    logic signed [WIDE_W-1:0] xa, ya, zb, xb, yc, zc;
    logic signed [WIDE_W-1:0] pz_z;
    logic signed [TRIG_W-1:0] cy_z, sy_z, cx_z, sx_z, cx_y, sx_y;
    logic signed [WIDE_W-1:0] yc_side_ya;
    logic signed [WIDE_W-1:0] xb_side;

    // depth stage
    vrp_ctl_t                 ctl_p1_reg;
    logic signed [ROT_W-1:0]  rx_p1_reg, ry_p1_reg, rz_p1_reg;
    logic signed [DEN_W-1:0]  den_p1_reg;
    logic signed [DEN_W-1:0]  den_next;

    // scale stage
    vrp_ctl_t                 ctl_p2_reg;
    logic signed [ROT_W-1:0]  rx_p2_reg, ry_p2_reg, rz_p2_reg;
    logic signed [PROJ_W-1:0] prod_x_reg, prod_y_reg;
    logic [DIVD_W-1:0]        dmag_p2_reg;
    logic                     den_ok_p2_reg;

    logic [NUM_W-1:0]         mag_x, mag_y;
    logic [SIDE_D-1:0]        side_d_in, side_d_out;
    logic [NUM_W-1:0]         quo_x, quo_y;

    logic signed [ROT_W-1:0]  rx_d, ry_d, rz_d;
    logic                     neg_x_d, neg_y_d, den_ok_d;

    // output stage
    vrp_ctl_t                 ctl_o_reg;
    logic signed [ROT_W-1:0]  rx_o_reg, ry_o_reg, rz_o_reg;
    logic signed [SCR_W-1:0]  sx_o_reg, sy_o_reg;
    status_t                  status_o_reg;
    logic signed [SCR_W-1:0]  scr_x_next, scr_y_next;
    logic                     sat_x, sat_y;
    status_t                  status_next;
    logic signed [DEN_W-1:0]  den_chk;

    assign en        = !ctl_o_reg.valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg  <= FOCAL_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FOCAL:  focal_reg  <= cfg_data[FOCAL_W-1:0];
                CFG_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                default:    ;
            endcase
        end
    end

    assign ctl_in.valid = in_valid;
    assign ctl_in.last  = last_vertex;

    vrp_trig u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_in),
        .px      (point_x),
        .py      (point_y),
        .pz      (point_z),
        .ax      (angle_x),
        .ay      (angle_y),
        .az      (angle_z),
        .ctl_out (ctl_t),
        .px_out  (px_t),
        .py_out  (py_t),
        .pz_out  (pz_t),
        .cx      (cx_t),
        .sx      (sx_t),
        .cy      (cy_t),
        .sy      (sy_t),
        .cz      (cz_t),
        .sz      (sz_t)
    );

    // about z
    vrp_rot_stage #(.SIDE_W(SIDE_Z)) u_rot_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (ctl_t),
        .a        (px_t),
        .b        (py_t),
        .c        (cz_t),
        .s        (sz_t),
        .side_in  ({pz_t, cy_t, sy_t, cx_t, sx_t}),
        .ctl_out  (ctl_z),
        .out1     (xa),
        .out2     (ya),
        .side_out ({pz_z, cy_z, sy_z, cx_z, sx_z})
    );

    // about y
    vrp_rot_stage #(.SIDE_W(SIDE_Y)) u_rot_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (ctl_z),
        .a        (pz_z),
        .b        (xa),
        .c        (cy_z),
        .s        (sy_z),
        .side_in  ({ya, cx_z, sx_z}),
        .ctl_out  (ctl_y),
        .out1     (zb),
        .out2     (xb),
        .side_out ({yc_side_ya, cx_y, sx_y})
    );

    // about x
    vrp_rot_stage #(.SIDE_W(SIDE_X)) u_rot_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (ctl_y),
        .a        (yc_side_ya),
        .b        (zb),
        .c        (cx_y),
        .s        (sx_y),
        .side_in  (xb),
        .ctl_out  (ctl_x),
        .out1     (yc),
        .out2     (zc),
        .side_out (xb_side)
    );

    assign den_next = DEN_W'(sat_rot(zc)) + DEN_W'({1'b0, focal_reg})
                    + DEN_W'({1'b0, offset_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_p1_reg <= '0;
            ctl_p2_reg <= '0;
            ctl_o_reg  <= '0;
        end
        else if (en)
        begin
            ctl_p1_reg <= ctl_x;
            ctl_p2_reg <= ctl_p1_reg;
            ctl_o_reg  <= ctl_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_p1_reg     <= sat_rot(xb_side);
            ry_p1_reg     <= sat_rot(yc);
            rz_p1_reg     <= sat_rot(zc);
            den_p1_reg    <= den_next;
            rx_p2_reg     <= rx_p1_reg;
            ry_p2_reg     <= ry_p1_reg;
            rz_p2_reg     <= rz_p1_reg;
            prod_x_reg    <= rx_p1_reg * $signed({1'b0, focal_reg});
            prod_y_reg    <= ry_p1_reg * $signed({1'b0, focal_reg});
            dmag_p2_reg   <= den_p1_reg[DIVD_W-1:0];
            den_ok_p2_reg <= !den_p1_reg[DEN_W-1] && (den_p1_reg != '0);
            rx_o_reg      <= rx_d;
            ry_o_reg      <= ry_d;
            rz_o_reg      <= rz_d;
            sx_o_reg      <= scr_x_next;
            sy_o_reg      <= scr_y_next;
            status_o_reg  <= status_next;
        end
    end

    assign mag_x = prod_x_reg[PROJ_W-1] ? NUM_W'(-prod_x_reg) : NUM_W'(prod_x_reg);
    assign mag_y = prod_y_reg[PROJ_W-1] ? NUM_W'(-prod_y_reg) : NUM_W'(prod_y_reg);
    assign side_d_in = {rx_p2_reg, ry_p2_reg, rz_p2_reg,
                        prod_x_reg[PROJ_W-1], prod_y_reg[PROJ_W-1], den_ok_p2_reg};

    vrp_div #(.NUM_W(NUM_W), .DEN_W(DIVD_W), .SIDE_W(SIDE_D)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (ctl_p2_reg),
        .num_a    (mag_x),
        .num_b    (mag_y),
        .den      (dmag_p2_reg),
        .side_in  (side_d_in),
        .ctl_out  (ctl_d),
        .quo_a    (quo_x),
        .quo_b    (quo_y),
        .side_out (side_d_out)
    );

    assign {rx_d, ry_d, rz_d, neg_x_d, neg_y_d, den_ok_d} = side_d_out;

    always_comb
    begin
        sat_x = neg_x_d ? (quo_x > NEG_LIMIT) : (quo_x > POS_LIMIT);
        sat_y = neg_y_d ? (quo_y > NEG_LIMIT) : (quo_y > POS_LIMIT);
        if (sat_x)
            scr_x_next = neg_x_d ? {1'b1, {(SCR_W-1){1'b0}}} : {1'b0, {(SCR_W-1){1'b1}}};
        else
            scr_x_next = neg_x_d ? -$signed(quo_x[SCR_W-1:0]) : $signed(quo_x[SCR_W-1:0]);
        if (sat_y)
            scr_y_next = neg_y_d ? {1'b1, {(SCR_W-1){1'b0}}} : {1'b0, {(SCR_W-1){1'b1}}};
        else
            scr_y_next = neg_y_d ? -$signed(quo_y[SCR_W-1:0]) : $signed(quo_y[SCR_W-1:0]);
        priority if (!den_ok_d)
        begin
            status_next = STATUS_DEN;
            scr_x_next  = '0;
            scr_y_next  = '0;
        end
        else if (sat_x || sat_y)
            status_next = STATUS_SAT;
        else
            status_next = STATUS_OK;
    end

    assign out_valid       = ctl_o_reg.valid;
    assign last_vertex_out = ctl_o_reg.last;
    assign rot_x           = rx_o_reg;
    assign rot_y           = ry_o_reg;
    assign rot_z           = rz_o_reg;
    assign screen_x        = sx_o_reg;
    assign screen_y        = sy_o_reg;
    assign status          = status_o_reg;

    assign den_chk = DEN_W'(rz_o_reg) + DEN_W'({1'b0, focal_reg}) + DEN_W'({1'b0, offset_reg});

`include "vertex_rotate_project_defines.svh"

    `VRP_ASSERT_NOW(a_den_zero_screen, out_valid && (status == STATUS_DEN),
        (screen_x == '0) && (screen_y == '0))
    `VRP_ASSERT_NOW(a_sat_at_limit, out_valid && (status == STATUS_SAT),
        (screen_x == 16'sh7FFF) || (screen_x == -16'sh8000) ||
        (screen_y == 16'sh7FFF) || (screen_y == -16'sh8000))
    `VRP_ASSERT_NOW(a_den_positive, out_valid && (status != STATUS_DEN),
        !den_chk[DEN_W-1] && (den_chk != '0))
    `VRP_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready && ctl_d.valid, out_valid && $stable(ctl_d))

endmodule

// ===== rtl/core/vrp_trig.sv =====
// angle wrap and sine/cosine lookup stage
module vrp_trig (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  vrp_pkg::vrp_ctl_t                   ctl_in,
    input  logic signed [vrp_pkg::COORD_W-1:0]  px,
    input  logic signed [vrp_pkg::COORD_W-1:0]  py,
    input  logic signed [vrp_pkg::COORD_W-1:0]  pz,
    input  logic        [vrp_pkg::ANG_W-1:0]    ax,
    input  logic        [vrp_pkg::ANG_W-1:0]    ay,
    input  logic        [vrp_pkg::ANG_W-1:0]    az,
    output vrp_pkg::vrp_ctl_t                   ctl_out,
    output logic signed [vrp_pkg::WIDE_W-1:0]   px_out,
    output logic signed [vrp_pkg::WIDE_W-1:0]   py_out,
    output logic signed [vrp_pkg::WIDE_W-1:0]   pz_out,
    output logic signed [vrp_pkg::TRIG_W-1:0]   cx,
    output logic signed [vrp_pkg::TRIG_W-1:0]   sx,
    output logic signed [vrp_pkg::TRIG_W-1:0]   cy,
    output logic signed [vrp_pkg::TRIG_W-1:0]   sy,
    output logic signed [vrp_pkg::TRIG_W-1:0]   cz,
    output logic signed [vrp_pkg::TRIG_W-1:0]   sz
);
    import vrp_pkg::*;

    vrp_ctl_t                  ctl_reg;
    logic signed [WIDE_W-1:0]  px_reg, py_reg, pz_reg;
    logic signed [TRIG_W-1:0]  cx_reg, sx_reg, cy_reg, sy_reg, cz_reg, sz_reg;
    logic        [ANG_W-1:0]   axw, ayw, azw;

    assign axw = wrap_deg(ax);
    assign ayw = wrap_deg(ay);
    assign azw = wrap_deg(az);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= WIDE_W'(px);
            py_reg <= WIDE_W'(py);
            pz_reg <= WIDE_W'(pz);
            cx_reg <= cos_deg(axw);
            sx_reg <= sin_deg(axw);
            cy_reg <= cos_deg(ayw);
            sy_reg <= sin_deg(ayw);
            cz_reg <= cos_deg(azw);
            sz_reg <= sin_deg(azw);
        end
    end

    assign ctl_out = ctl_reg;
    assign px_out  = px_reg;
    assign py_out  = py_reg;
    assign pz_out  = pz_reg;
    assign cx      = cx_reg;
    assign sx      = sx_reg;
    assign cy      = cy_reg;
    assign sy      = sy_reg;
    assign cz      = cz_reg;
    assign sz      = sz_reg;

endmodule

// ===== rtl/core/vrp_rot_stage.sv =====
// one axis rotation: multiply stage then add and truncate stage
module vrp_rot_stage #(
    parameter int SIDE_W = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  vrp_pkg::vrp_ctl_t                  ctl_in,
    input  logic signed [vrp_pkg::WIDE_W-1:0]  a,
    input  logic signed [vrp_pkg::WIDE_W-1:0]  b,
    input  logic signed [vrp_pkg::TRIG_W-1:0]  c,
    input  logic signed [vrp_pkg::TRIG_W-1:0]  s,
    input  logic        [SIDE_W-1:0]           side_in,
    output vrp_pkg::vrp_ctl_t                  ctl_out,
    output logic signed [vrp_pkg::WIDE_W-1:0]  out1,
    output logic signed [vrp_pkg::WIDE_W-1:0]  out2,
    output logic        [SIDE_W-1:0]           side_out
);
    import vrp_pkg::*;

    vrp_ctl_t                 ctl_m_reg, ctl_s_reg;
    logic signed [PROD_W-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic        [SIDE_W-1:0] side_m_reg, side_s_reg;
    logic signed [WIDE_W-1:0] out1_reg, out2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_m_reg <= '0;
            ctl_s_reg <= '0;
        end
        else if (en)
        begin
            ctl_m_reg <= ctl_in;
            ctl_s_reg <= ctl_m_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ac_reg     <= a * c;
            bs_reg     <= b * s;
            as_reg     <= a * s;
            bc_reg     <= b * c;
            side_m_reg <= side_in;
            out1_reg   <= trunc_q(SUM_W'(ac_reg) - SUM_W'(bs_reg));
            out2_reg   <= trunc_q(SUM_W'(as_reg) + SUM_W'(bc_reg));
            side_s_reg <= side_m_reg;
        end
    end

    assign ctl_out  = ctl_s_reg;
    assign out1     = out1_reg;
    assign out2     = out2_reg;
    assign side_out = side_s_reg;

endmodule

// ===== rtl/core/vrp_div.sv =====
// two lane pipelined restoring divider, one quotient bit per stage
module vrp_div #(
    parameter int NUM_W  = vrp_pkg::NUM_W,
    parameter int DEN_W  = vrp_pkg::DIVD_W,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  vrp_pkg::vrp_ctl_t   ctl_in,
    input  logic [NUM_W-1:0]    num_a,
    input  logic [NUM_W-1:0]    num_b,
    input  logic [DEN_W-1:0]    den,
    input  logic [SIDE_W-1:0]   side_in,
    output vrp_pkg::vrp_ctl_t   ctl_out,
    output logic [NUM_W-1:0]    quo_a,
    output logic [NUM_W-1:0]    quo_b,
    output logic [SIDE_W-1:0]   side_out
);
    import vrp_pkg::*;

    vrp_ctl_t          ctl_reg  [1:NUM_W];
    logic [DEN_W-1:0]  rem_a_reg [1:NUM_W];
    logic [DEN_W-1:0]  rem_b_reg [1:NUM_W];
    logic [NUM_W-1:0]  num_a_reg [1:NUM_W];
    logic [NUM_W-1:0]  num_b_reg [1:NUM_W];
    logic [NUM_W-1:0]  quo_a_reg [1:NUM_W];
    logic [NUM_W-1:0]  quo_b_reg [1:NUM_W];
    logic [DEN_W-1:0]  den_reg  [1:NUM_W];
    logic [SIDE_W-1:0] side_reg [1:NUM_W];

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_stage
        vrp_ctl_t          ctl_cur;
        logic [DEN_W-1:0]  rem_a_cur, rem_b_cur, den_cur;
        logic [NUM_W-1:0]  num_a_cur, num_b_cur, quo_a_cur, quo_b_cur;
        logic [SIDE_W-1:0] side_cur;
        logic [DEN_W:0]    trial_a, trial_b;
        logic              ge_a, ge_b;

        if (i == 0)
        begin : g_first
            assign ctl_cur   = ctl_in;
            assign rem_a_cur = '0;
            assign rem_b_cur = '0;
            assign num_a_cur = num_a;
            assign num_b_cur = num_b;
            assign quo_a_cur = '0;
            assign quo_b_cur = '0;
            assign den_cur   = den;
            assign side_cur  = side_in;
        end
        else
        begin : g_next
            assign ctl_cur   = ctl_reg[i];
            assign rem_a_cur = rem_a_reg[i];
            assign rem_b_cur = rem_b_reg[i];
            assign num_a_cur = num_a_reg[i];
            assign num_b_cur = num_b_reg[i];
            assign quo_a_cur = quo_a_reg[i];
            assign quo_b_cur = quo_b_reg[i];
            assign den_cur   = den_reg[i];
            assign side_cur  = side_reg[i];
        end

        assign trial_a = {rem_a_cur, num_a_cur[NUM_W-1]};
        assign trial_b = {rem_b_cur, num_b_cur[NUM_W-1]};
        assign ge_a    = trial_a >= {1'b0, den_cur};
        assign ge_b    = trial_b >= {1'b0, den_cur};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i+1] <= '0;
            end
            else if (en)
            begin
                ctl_reg[i+1] <= ctl_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_a_reg[i+1] <= ge_a ? DEN_W'(trial_a - {1'b0, den_cur}) : DEN_W'(trial_a);
                rem_b_reg[i+1] <= ge_b ? DEN_W'(trial_b - {1'b0, den_cur}) : DEN_W'(trial_b);
                num_a_reg[i+1] <= {num_a_cur[NUM_W-2:0], 1'b0};
                num_b_reg[i+1] <= {num_b_cur[NUM_W-2:0], 1'b0};
                quo_a_reg[i+1] <= {quo_a_cur[NUM_W-2:0], ge_a};
                quo_b_reg[i+1] <= {quo_b_cur[NUM_W-2:0], ge_b};
                den_reg[i+1]   <= den_cur;
                side_reg[i+1]  <= side_cur;
            end
        end
    end

    assign ctl_out  = ctl_reg[NUM_W];
    assign quo_a    = quo_a_reg[NUM_W];
    assign quo_b    = quo_b_reg[NUM_W];
    assign side_out = side_reg[NUM_W];

endmodule
